// ----- rtl/lzssw_pkg.sv -----
package lzssw_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int LEN_BITS       = 24;
  localparam int WIN_BITS       = 12;
  localparam int FILL_BITS      = WIN_BITS + 1;
  localparam int REM_BITS       = 5;
  localparam int UPC_BITS       = 2;
  localparam int UCODE_DEPTH    = 1 << UPC_BITS;

  localparam logic [WIN_BITS-1:0] WIN_START = 12'd4078;
  localparam logic [7:0]          FILL_BYTE = 8'h20;

  typedef logic [UPC_BITS-1:0] upc_t;

  localparam upc_t ADDR_FETCH = 2'd0;
  localparam upc_t ADDR_LIT   = 2'd1;
  localparam upc_t ADDR_PRIME = 2'd2;
  localparam upc_t ADDR_COPY  = 2'd3;

  typedef enum logic [1:0] {
    OP_ACCEPT,
    OP_EMIT_LIT,
    OP_PRIME,
    OP_COPY
  } op_t;

  typedef enum logic [1:0] {
    SEQ_DISPATCH,
    SEQ_NEXT,
    SEQ_WAIT_OUT,
    SEQ_COPY
  } seq_t;

  typedef enum logic [2:0] {
    KIND_IGNORE,
    KIND_FLAG,
    KIND_LIT,
    KIND_LOW,
    KIND_HIGH
  } kind_t;

  typedef struct packed {
    op_t  op;
    seq_t seq;
    upc_t target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic  in_valid;
    logic  out_free;
    logic  last;
    kind_t kind;
  } status_t;

  // control store, one word per step
  localparam uword_t UCODE [UCODE_DEPTH] = '{
    '{op: OP_ACCEPT,   seq: SEQ_DISPATCH, target: ADDR_FETCH},
    '{op: OP_EMIT_LIT, seq: SEQ_WAIT_OUT, target: ADDR_FETCH},
    '{op: OP_PRIME,    seq: SEQ_NEXT,     target: ADDR_COPY},
    '{op: OP_COPY,     seq: SEQ_COPY,     target: ADDR_FETCH}
  };

  // mapping from decoded word kind to entry step
  function automatic upc_t dispatch(input kind_t kind);
    upc_t tgt;
    unique case (kind)
      KIND_LIT:  tgt = ADDR_LIT;
      KIND_HIGH: tgt = ADDR_PRIME;
      default:   tgt = ADDR_FETCH;
    endcase
    return tgt;
  endfunction

endpackage

// ----- rtl/lzss_window_decompressor.sv -----
// LZSS decoder with a 4096-byte history window. One compressed byte is taken per
// input word; flag bytes and match low bytes are only accepted, a literal is
// accepted and then emitted, and a match high byte is accepted, primes the window
// read, then copies up to its length code plus three window bytes. The window
// RAM, single-port per side with a registered read, sets the copy rate of one
// byte per cycle while the output is not stalled; an output stall holds the literal
// emit and each copied byte. Restart via new_stream is immediate: a fill count
// marks which window bytes were written since restart and the rest read as spaces,
// so there is no clearing pass. Write output_length only while the block is idle.
module lzss_window_decompressor #(
  parameter int COUNT_BITS = lzssw_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  input  logic                           new_stream,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           last_of_run,
  output logic                           stream_done,
  input  logic                           cfg_write,
  input  logic [lzssw_pkg::LEN_BITS-1:0] cfg_data
);

  lzssw_pkg::ctrl_t   ctrl;
  lzssw_pkg::status_t status;

  assign in_stall = (ctrl.op != lzssw_pkg::OP_ACCEPT);

  lzssw_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  lzssw_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .new_stream  (new_stream),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stream_done (stream_done),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data)
  );

endmodule

// ----- rtl/lzssw_useq.sv -----
module lzssw_useq (
  input  logic              clk,
  input  logic              rst,
  input  lzssw_pkg::status_t status,
  output lzssw_pkg::ctrl_t   ctrl
);

  lzssw_pkg::upc_t   upc;
  lzssw_pkg::upc_t   upc_next;
  lzssw_pkg::uword_t uw;

  assign uw      = lzssw_pkg::UCODE[upc];
  assign ctrl.op = uw.op;

  always_comb begin
    upc_next = upc;
    unique case (uw.seq)
      lzssw_pkg::SEQ_DISPATCH: begin
        if (status.in_valid) upc_next = lzssw_pkg::dispatch(status.kind);
      end
      lzssw_pkg::SEQ_NEXT: begin
        upc_next = upc + lzssw_pkg::upc_t'(1);
      end
      lzssw_pkg::SEQ_WAIT_OUT: begin
        if (status.out_free) upc_next = uw.target;
      end
      lzssw_pkg::SEQ_COPY: begin
        if (status.out_free && status.last) upc_next = uw.target;
      end
      default: upc_next = lzssw_pkg::ADDR_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= lzssw_pkg::ADDR_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ----- rtl/lzssw_datapath.sv -----
module lzssw_datapath #(
  parameter int COUNT_BITS = lzssw_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lzssw_pkg::ctrl_t                ctrl,
  output lzssw_pkg::status_t              status,
  input  logic                            in_valid,
  input  logic [7:0]                      in_byte,
  input  logic                            new_stream,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            last_of_run,
  output logic                            stream_done,
  input  logic                            cfg_write,
  input  logic [lzssw_pkg::LEN_BITS-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_BYTE,
    PH_HIGH
  } phase_t;

  localparam int WB = lzssw_pkg::WIN_BITS;

  logic [7:0] win [1 << WB];

  logic [lzssw_pkg::LEN_BITS-1:0]  output_length;
  logic [COUNT_BITS-1:0]           count;
  logic [lzssw_pkg::FILL_BITS-1:0] fill;
  logic [WB-1:0]                   wp;
  logic [WB-1:0]                   rp;
  phase_t                          phase;
  logic [8:0]                      flags;
  logic [7:0]                      held_low;
  logic [7:0]                      hold_byte;
  logic [lzssw_pkg::REM_BITS-1:0]  rem;
  logic [7:0]                      rd_data;
  logic                            vld_q;
  logic                            byp_q;
  logic [7:0]                      byp_data;

  logic [31:0]           len_ext;
  logic [COUNT_BITS-1:0] limit;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] eff_count;
  phase_t                eff_phase;
  logic [8:0]            eff_flags;
  logic [8:0]            shifted;
  lzssw_pkg::kind_t      kind;
  logic                  accept;
  logic                  out_free;
  logic                  emit_lit;
  logic                  emit_copy;
  logic                  wr_en;
  logic                  rd_en;
  logic                  emit_done;
  logic [7:0]            copy_byte;
  logic [7:0]            emit_byte;
  logic [WB-1:0]         rel;

  assign len_ext   = 32'(output_length);
  assign limit     = len_ext[COUNT_BITS-1:0];
  assign count_inc = count + COUNT_BITS'(1);
  assign emit_done = count_inc >= limit;

  assign accept    = (ctrl.op == lzssw_pkg::OP_ACCEPT) && in_valid;
  assign eff_count = new_stream ? '0 : count;
  assign eff_phase = new_stream ? PH_FLAG : phase;
  assign eff_flags = new_stream ? 9'd0 : flags;
  assign shifted   = {1'b0, eff_flags[8:1]};

  always_comb begin
    if (eff_count >= limit) begin
      kind = lzssw_pkg::KIND_IGNORE;
    end else begin
      unique case (eff_phase)
        PH_BYTE: kind = eff_flags[0] ? lzssw_pkg::KIND_LIT : lzssw_pkg::KIND_LOW;
        PH_HIGH: kind = lzssw_pkg::KIND_HIGH;
        default: kind = lzssw_pkg::KIND_FLAG;
      endcase
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign emit_lit  = (ctrl.op == lzssw_pkg::OP_EMIT_LIT) && out_free;
  assign emit_copy = (ctrl.op == lzssw_pkg::OP_COPY) && out_free;
  assign wr_en     = emit_lit || emit_copy;
  assign rd_en     = (ctrl.op == lzssw_pkg::OP_PRIME) || emit_copy;

  // entries not yet written since restart read back as spaces
  assign copy_byte = byp_q ? byp_data : (vld_q ? rd_data : lzssw_pkg::FILL_BYTE);
  assign emit_byte = (ctrl.op == lzssw_pkg::OP_COPY) ? copy_byte : hold_byte;
  assign rel       = rp - lzssw_pkg::WIN_START;

  assign status.in_valid = in_valid;
  assign status.out_free = out_free;
  assign status.last     = (rem == '0) || emit_done;
  assign status.kind     = kind;

  always_ff @(posedge clk) begin
    if (wr_en) win[wp] <= emit_byte;
    if (rd_en) begin
      rd_data  <= win[rp];
      vld_q    <= {1'b0, rel} < fill;
      // overlapping copy: the byte being written now is the one being read
      byp_q    <= wr_en && (rp == wp);
      byp_data <= emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
      count         <= '0;
      fill          <= '0;
      wp            <= lzssw_pkg::WIN_START;
      phase         <= PH_FLAG;
      flags         <= '0;
      held_low      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) output_length <= cfg_data;

      if (accept) begin
        hold_byte <= in_byte;
        if (new_stream) begin
          count    <= '0;
          fill     <= '0;
          wp       <= lzssw_pkg::WIN_START;
          held_low <= '0;
        end
        unique case (kind)
          lzssw_pkg::KIND_FLAG: begin
            flags <= {1'b1, in_byte};
            phase <= PH_BYTE;
          end
          lzssw_pkg::KIND_LIT: begin
            flags <= shifted;
            phase <= (shifted[8:1] == '0) ? PH_FLAG : PH_BYTE;
          end
          lzssw_pkg::KIND_LOW: begin
            flags    <= shifted;
            held_low <= in_byte;
            phase    <= PH_HIGH;
          end
          lzssw_pkg::KIND_HIGH: begin
            rp    <= {in_byte[7:4], held_low};
            rem   <= lzssw_pkg::REM_BITS'(in_byte[3:0]) + lzssw_pkg::REM_BITS'(2);
            phase <= (eff_flags[8:1] == '0) ? PH_FLAG : PH_BYTE;
          end
          default: begin
            // ignored word still carries a restart
            flags <= eff_flags;
            phase <= eff_phase;
          end
        endcase
      end

      if (rd_en) rp <= rp + WB'(1);
      if (emit_copy) rem <= rem - lzssw_pkg::REM_BITS'(1);

      if (wr_en) begin
        wp          <= wp + WB'(1);
        count       <= count_inc;
        fill        <= fill[WB] ? fill : fill + lzssw_pkg::FILL_BITS'(1);
        out_valid   <= 1'b1;
        out_byte    <= emit_byte;
        stream_done <= emit_done;
        last_of_run <= emit_lit || status.last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/lzssw_checker.sv -----
module lzssw_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       stream_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(last_of_run) && $stable(stream_done))
    else $error("stalled output word changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> last_of_run)
    else $error("stream end not flagged as last of run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word after reset");

  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done && !out_stall |=> !out_valid)
    else $error("word straight after stream end");

endmodule

bind lzss_window_decompressor lzssw_checker u_chk (.*);

// ----- tb/sv/lzss_window_decompressor_tb.sv -----
module lzss_window_decompressor_tb;

  typedef enum logic [1:0] {
    WANT_FLAGS,
    WANT_LIT_OR_LOW,
    WANT_HIGH
  } decode_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       restart;
  } comp_word_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       done;
  } plain_byte_t;

  localparam int LONG_HOLD = 400;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_byte = 8'h00;
  logic                           new_stream = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_byte;
  logic                           last_of_run;
  logic                           stream_done;
  logic                           cfg_write = 1'b0;
  logic [lzssw_pkg::LEN_BITS-1:0] cfg_data = '0;

  comp_word_t  pending_words[$];
  plain_byte_t expected_bytes[$];

  // decoder copy kept by the bench
  logic [7:0]                     hist [4096];
  logic [11:0]                    wr_pos;
  logic [8:0]                     flag_bits;
  decode_phase_t                  phase;
  logic [7:0]                     held_low;
  logic [23:0]                    produced;
  logic [lzssw_pkg::LEN_BITS-1:0] byte_limit;

  int    words_queued = 0;
  int    words_taken = 0;
  int    bytes_checked = 0;
  int    cfg_writes = 0;
  int    errors = 0;
  int    in_gap = 0;
  int    in_pace = 0;
  int    out_wait = 0;
  int    out_pace = 1;
  int    hold_left = 0;
  bit    hold_armed = 1'b0;
  bit    hold_taken = 1'b0;
  bit    broken = 1'b0;
  logic [11:0] gen_pos = lzssw_pkg::WIN_START;

  lzss_window_decompressor i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .new_stream  (new_stream),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stream_done (stream_done),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap(input int pace);
    if (pace == 0) return 0;
    if (pace == 1) return $urandom_range(0, 18);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
  endfunction

  task automatic restart_decoder();
    for (int i = 0; i < 4096; i++) hist[i] = lzssw_pkg::FILL_BYTE;
    wr_pos = lzssw_pkg::WIN_START;
    flag_bits = '0;
    phase = WANT_FLAGS;
    held_low = '0;
    produced = '0;
  endtask

  function automatic bit emit_byte(input logic [7:0] b);
    plain_byte_t e;
    hist[wr_pos] = b;
    wr_pos = wr_pos + 12'd1;
    produced = produced + 24'd1;
    e.data = b;
    e.last = 1'b0;
    e.done = (produced >= byte_limit);
    expected_bytes.push_back(e);
    return e.done;
  endfunction

  task automatic decode_word(input logic [7:0] b, input logic restart);
    int          first;
    int          len;
    bit          stop;
    bit          lit;
    logic [11:0] src;
    logic [11:0] rd;
    first = expected_bytes.size();
    if (restart) restart_decoder();
    if (produced >= byte_limit) return;
    case (phase)
      WANT_LIT_OR_LOW: begin
        lit = flag_bits[0];
        flag_bits = flag_bits >> 1;
        if (lit) begin
          void'(emit_byte(b));
          if (flag_bits <= 9'd1) phase = WANT_FLAGS;
          else phase = WANT_LIT_OR_LOW;
        end else begin
          held_low = b;
          phase = WANT_HIGH;
        end
      end
      WANT_HIGH: begin
        src = {b[7:4], held_low};
        len = int'(b[3:0]) + 3;
        stop = 1'b0;
        // window is updated byte by byte, so overlapping copies repeat
        for (int i = 0; i < len && !stop; i++) begin
          rd = src + 12'(i);
          stop = emit_byte(hist[rd]);
        end
        if (flag_bits <= 9'd1) phase = WANT_FLAGS;
        else phase = WANT_LIT_OR_LOW;
      end
      default: begin
        flag_bits = {1'b1, b};
        phase = WANT_LIT_OR_LOW;
      end
    endcase
    if (expected_bytes.size() > first) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endtask

  // sender
  always @(posedge clk) begin
    comp_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_byte <= w.data;
        new_stream <= w.restart;
        in_valid <= 1'b1;
        if ($urandom_range(0, 23) == 0) in_pace = $urandom_range(0, 2);
        in_gap = pick_gap(in_pace);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 31) == 0) out_pace = $urandom_range(0, 2);
        out_wait = pick_gap(out_pace);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_armed && !hold_taken && out_valid) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // predict on input words, check output words
  always @(posedge clk) begin
    plain_byte_t want;
    if (rst) begin
      restart_decoder();
      byte_limit = '0;
    end else begin
      if (cfg_write) byte_limit = cfg_data;
      if (in_valid && !in_stall) begin
        decode_word(in_byte, new_stream);
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected word: out_byte %02h last_of_run %0b stream_done %0b",
                 out_byte, last_of_run, stream_done);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
            errors++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
            errors++;
          end
          if (stream_done !== want.done) begin
            $error("stream_done: expected %0b, actual %0b", want.done, stream_done);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic restart);
    comp_word_t w;
    w.data = b;
    w.restart = restart;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic write_limit(input logic [lzssw_pkg::LEN_BITS-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_writes++;
  endtask

  // all words taken and all bytes out, then let a match still in flight settle
  task automatic drain();
    do @(posedge clk);
    while (words_taken != words_queued || expected_bytes.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  // one flag byte and its eight items; sometimes cut short
  task automatic send_group(input bit restart);
    logic [7:0]  flags;
    logic [11:0] src;
    logic [3:0]  len_code;
    int          cut;
    case ($urandom_range(0, 5))
      0:       flags = 8'hFF;
      1:       flags = 8'h00;
      default: flags = 8'($urandom_range(0, 255));
    endcase
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
    broken = (cut < 8);
    if (restart) gen_pos = lzssw_pkg::WIN_START;
    push_word(flags, restart);
    for (int i = 0; i < cut; i++) begin
      if (flags[i]) begin
        push_word(8'($urandom_range(0, 255)), 1'b0);
        gen_pos = gen_pos + 12'd1;
      end else begin
        len_code = 4'($urandom_range(0, 15));
        // mostly close behind the write point, so copies hit fresh and overlapping data
        if ($urandom_range(0, 3) == 0) src = 12'($urandom_range(0, 4095));
        else src = gen_pos - 12'($urandom_range(1, 24));
        push_word(src[7:0], 1'b0);
        push_word({src[11:8], len_code}, 1'b0);
        gen_pos = gen_pos + 12'(len_code) + 12'd3;
      end
    end
  endtask

  initial begin
    logic [lzssw_pkg::LEN_BITS-1:0] lim;
    bit                             short_lim;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero length after reset: nothing comes out
    push_word(8'hFF, 1'b1);
    push_word(8'h41, 1'b0);
    drain();

    write_limit({lzssw_pkg::LEN_BITS{1'b1}});
    push_word(8'hA5, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'hEE, 1'b0);
    push_word(8'hF0, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h80, 1'b0);
    push_word(8'h08, 1'b0);  // copy from one behind the write point
    push_word(8'h07, 1'b0);
    push_word(8'h7F, 1'b0);
    drain();

    // long match truncated by the limit, then words ignored
    write_limit(24'd5);
    push_word(8'hFE, 1'b1);
    push_word(8'h10, 1'b0);
    push_word(8'h0F, 1'b0);
    push_word(8'h33, 1'b0);
    push_word(8'h44, 1'b0);
    drain();
    write_limit(24'd8);
    push_word(8'h55, 1'b0);
    drain();
    write_limit(24'd3);
    push_word(8'h66, 1'b0);
    push_word(8'h01, 1'b1);
    push_word(8'h41, 1'b0);
    drain();

    hold_armed = 1'b1;
    write_limit({lzssw_pkg::LEN_BITS{1'b1}});
    send_group(1'b1);
    repeat (7) send_group(broken);
    drain();

    write_limit(24'd1);
    repeat (4) begin
      push_word(8'($urandom_range(0, 255)), 1'b1);
      push_word(8'($urandom_range(0, 255)), 1'b0);
    end
    drain();

    while (words_queued < 340) begin
      case ($urandom_range(0, 3))
        0:       lim = {lzssw_pkg::LEN_BITS{1'b1}};
        1:       lim = lzssw_pkg::LEN_BITS'($urandom_range(0, 24'hFFFFFF));
        default: lim = lzssw_pkg::LEN_BITS'($urandom_range(20, 120));
      endcase
      short_lim = (lim <= 120);
      write_limit(lim);
      send_group(1'b1);
      repeat ($urandom_range(2, 5))
        send_group(broken || short_lim || ($urandom_range(0, 7) == 0));
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 6))
          push_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
      drain();
    end

    write_limit('0);
    push_word(8'($urandom_range(0, 255)), 1'b1);
    push_word(8'($urandom_range(0, 255)), 1'b0);
    drain();

    $display("%0d compressed words taken, %0d decoded bytes compared", words_taken, bytes_checked);
    $display("%0d length settings from zero to all ones, one long output hold", cfg_writes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(12 * 800000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lzssw_pkg.sv
rtl/lzssw_useq.sv
rtl/lzssw_datapath.sv
rtl/lzss_window_decompressor.sv
rtl/lzssw_checker.sv
tb/sv/lzss_window_decompressor_tb.sv
